@@ hw/rtl/mm_pkg.sv @@
package mm_pkg;

    // Fixed field widths of the stream words and configuration registers.
    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 6;
    localparam int VALUE_W   = 16;
    localparam int PRODUCT_W = 35;
    localparam int POS_W     = 3;
    localparam int DIM_CFG_W = 4;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_A = 2'd0,
        CMD_WRITE_B = 2'd1,
        CMD_COMPUTE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_ROWS_M  = 2'd0,
        CFG_INNER_K = 2'd1,
        CFG_COLS_N  = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    // Tag that travels down the multiply-accumulate pipeline with each read.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic             last_elem;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } mm_tag_t;

    // A dimension of zero counts as one, any value above the maximum as the maximum.
    function automatic logic [DIM_CFG_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] d,
                                                        input int max_dim);
        logic [DIM_CFG_W-1:0] res;
        res = d;
        if (d == '0)
        begin
            res = DIM_CFG_W'(1);
        end
        else if (int'(d) > max_dim)
        begin
            res = DIM_CFG_W'(max_dim);
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/mm_seq.sv @@
module mm_seq #(
    parameter int MAX_DIM = 8,
    parameter int DW      = 4,
    parameter int AW      = 6
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [DW-1:0]   m_dim,
    input  logic [DW-1:0]   k_dim,
    input  logic [DW-1:0]   n_dim,
    input  logic            adv,
    output logic            busy,
    output logic [AW-1:0]   a_addr,
    output logic [AW-1:0]   b_addr,
    output mm_pkg::mm_tag_t tag
);
    import mm_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    seq_state_t    state_reg, state_next;
    logic [IW-1:0] r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic [AW-1:0] a_base_reg, a_base_next, a_addr_reg, a_addr_next, b_addr_reg, b_addr_next;
    logic [DW-1:0] md_reg, md_next, kd_reg, kd_next, nd_reg, nd_next;
    logic          k_end, c_end, r_end;

    assign k_end = (DW'(k_reg) + DW'(1)) == kd_reg;
    assign c_end = (DW'(c_reg) + DW'(1)) == nd_reg;
    assign r_end = (DW'(r_reg) + DW'(1)) == md_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        c_reg      <= c_next;
        k_reg      <= k_next;
        a_base_reg <= a_base_next;
        a_addr_reg <= a_addr_next;
        b_addr_reg <= b_addr_next;
        md_reg     <= md_next;
        kd_reg     <= kd_next;
        nd_reg     <= nd_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        k_next      = k_reg;
        a_base_next = a_base_reg;
        a_addr_next = a_addr_reg;
        b_addr_next = b_addr_reg;
        md_next     = md_reg;
        kd_next     = kd_reg;
        nd_next     = nd_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next  = SEQ_RUN;
                    md_next     = m_dim;
                    kd_next     = k_dim;
                    nd_next     = n_dim;
                    r_next      = '0;
                    c_next      = '0;
                    k_next      = '0;
                    a_base_next = '0;
                    a_addr_next = '0;
                    b_addr_next = '0;
                end
            end
            SEQ_RUN:
            begin
                if (adv)
                begin
                    if (!k_end)
                    begin
                        k_next      = k_reg + IW'(1);
                        a_addr_next = a_addr_reg + AW'(1);
                        b_addr_next = b_addr_reg + AW'(nd_reg);
                    end
                    else
                    begin
                        k_next = '0;
                        if (!c_end)
                        begin
                            c_next      = c_reg + IW'(1);
                            a_addr_next = a_base_reg;
                            b_addr_next = AW'(c_reg) + AW'(1);
                        end
                        else
                        begin
                            c_next      = '0;
                            b_addr_next = '0;
                            r_next      = r_reg + IW'(1);
                            a_base_next = a_base_reg + AW'(kd_reg);
                            a_addr_next = a_base_reg + AW'(kd_reg);
                            if (r_end)
                            begin
                                state_next = SEQ_IDLE;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg == SEQ_RUN);
    assign a_addr        = a_addr_reg;
    assign b_addr        = b_addr_reg;
    assign tag.valid     = (state_reg == SEQ_RUN);
    assign tag.first     = (k_reg == '0);
    assign tag.last_k    = k_end;
    assign tag.last_elem = k_end && c_end && r_end;
    assign tag.row       = POS_W'(r_reg);
    assign tag.col       = POS_W'(c_reg);

endmodule

@@ hw/rtl/matrix_multiply.sv @@
// Channel   Dir  Handshake                    Word contents (lowest bit first)
// s_axis    in   s_axis_tvalid/s_axis_tready  command, element_index, element_value
// m_axis    out  m_axis_tvalid/m_axis_tready  product_value, out_row, out_col; tlast
// cfg       in   cfg_we                       cfg_index selects rows_m/inner_k/cols_n
//
// A write word stores one element of A or B.
// A compute word closes the input while the sequencer runs; the sequencer issues one
// read of A and one of B per cycle unless the output stalls, and a single
// multiply-accumulate unit sums K products per result, with the reads, product
// and sum registered. Reset clears only control state; the element memories hold whatever
// was last written. A stalled output freezes the whole read and accumulate pipeline.
module matrix_multiply #(
    parameter int MAX_DIM       = 8,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // command[1:0], element_index[7:2], element_value[23:8]
    input  logic [mm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // product_value[34:0], out_row[37:35], out_col[40:38], zeros above
    output logic [mm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [mm_pkg::DIM_CFG_W-1:0]    cfg_data
);
    import mm_pkg::*;

    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW      = $clog2(MAX_DIM + 1);
    localparam int EW      = ELEMENT_WIDTH;
    localparam int PROD_W  = 2 * EW;
    localparam int ACC_W   = PROD_W + 4;
    localparam int EXT_W   = (ACC_W > PRODUCT_W) ? ACC_W : PRODUCT_W;
    localparam int VEXT_W  = (EW > VALUE_W) ? EW : VALUE_W;

    // Configuration registers, taken as written and clamped on use.
    logic [DIM_CFG_W-1:0] rows_m_reg, inner_k_reg, cols_n_reg;
    logic [DW-1:0]        m_dim, k_dim, n_dim;

    // Input word fields.
    logic [CMD_W-1:0]         in_cmd;
    logic [INDEX_W-1:0]       in_index;
    logic signed [VALUE_W-1:0] in_value;
    logic signed [VEXT_W-1:0] value_ext;
    logic [EW-1:0]            wr_data;
    logic                     in_accept, wr_in_range, start;

    // Element memories, one read port each, read data registered.
    logic [EW-1:0] a_mem [DEPTH];
    logic [EW-1:0] b_mem [DEPTH];
    logic signed [EW-1:0] a_rd_reg, b_rd_reg;

    logic          busy, adv;
    logic [AW-1:0] a_addr, b_addr;
    mm_tag_t       seq_tag, s1_tag_reg, s2_tag_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_sum;
    logic signed [EXT_W-1:0]  acc_ext;

    logic                 out_valid_reg, out_valid_next, out_load;
    logic [PRODUCT_W-1:0] out_product_reg;
    logic [POS_W-1:0]     out_row_reg, out_col_reg;
    logic                 out_last_reg;

    assign in_cmd   = s_axis_tdata[1:0];
    assign in_index = s_axis_tdata[7:2];
    assign in_value = s_axis_tdata[23:8];

    // Narrower elements keep the low bits; wider ones are sign-extended.
    assign value_ext = VEXT_W'(in_value);
    assign wr_data   = value_ext[EW-1:0];

    assign s_axis_tready = !busy;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign wr_in_range   = ({1'b0, in_index} < (INDEX_W + 1)'(DEPTH));
    assign start         = in_accept && (in_cmd == CMD_COMPUTE);

    assign m_dim = DW'(clamp_dim(rows_m_reg, MAX_DIM));
    assign k_dim = DW'(clamp_dim(inner_k_reg, MAX_DIM));
    assign n_dim = DW'(clamp_dim(cols_n_reg, MAX_DIM));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg  <= DIM_CFG_W'(8);
            inner_k_reg <= DIM_CFG_W'(8);
            cols_n_reg  <= DIM_CFG_W'(8);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROWS_M:  rows_m_reg  <= cfg_data;
                CFG_INNER_K: inner_k_reg <= cfg_data;
                CFG_COLS_N:  cols_n_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Writes are only accepted while the sequencer is idle, so a write never
    // races a read of the same entry and no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (in_accept && wr_in_range && (in_cmd == CMD_WRITE_A))
        begin
            a_mem[AW'(in_index)] <= wr_data;
        end
        if (in_accept && wr_in_range && (in_cmd == CMD_WRITE_B))
        begin
            b_mem[AW'(in_index)] <= wr_data;
        end
        if (adv && seq_tag.valid)
        begin
            a_rd_reg <= a_mem[a_addr];
            b_rd_reg <= b_mem[b_addr];
        end
    end

    // The pipeline moves whenever the output register is free or being emptied.
    assign adv = !out_valid_reg || m_axis_tready;

    mm_seq #(
        .MAX_DIM (MAX_DIM),
        .DW      (DW),
        .AW      (AW)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .m_dim  (m_dim),
        .k_dim  (k_dim),
        .n_dim  (n_dim),
        .adv    (adv),
        .busy   (busy),
        .a_addr (a_addr),
        .b_addr (b_addr),
        .tag    (seq_tag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
        end
        else if (adv)
        begin
            s1_tag_reg <= seq_tag;
            s2_tag_reg <= s1_tag_reg;
        end
    end

    // Multiply stage, then accumulate stage.
    always_ff @(posedge clk)
    begin
        if (adv && s1_tag_reg.valid)
        begin
            prod_reg <= a_rd_reg * b_rd_reg;
        end
        if (adv && s2_tag_reg.valid)
        begin
            acc_reg <= acc_sum;
        end
    end

    // Each result starts its sum from zero on its first product.
    assign acc_sum = (s2_tag_reg.first ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
    assign acc_ext = EXT_W'(acc_sum);

    assign out_load       = adv && s2_tag_reg.valid && s2_tag_reg.last_k;
    assign out_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_product_reg <= acc_ext[PRODUCT_W-1:0];
            out_row_reg     <= s2_tag_reg.row;
            out_col_reg     <= s2_tag_reg.col;
            out_last_reg    <= s2_tag_reg.last_elem;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - PRODUCT_W - 2 * POS_W)'(0),
                            out_col_reg, out_row_reg, out_product_reg};
    assign m_axis_tlast  = out_last_reg;

    // The final element of a matrix is also the final product of its sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_tag_reg.valid && s2_tag_reg.last_elem |-> s2_tag_reg.last_k)
        else $error("last element flagged before its last product");

    // A compute word must start the sequencer and close the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (in_cmd == CMD_COMPUTE) |=> !s_axis_tready)
        else $error("compute word accepted but sequencer did not start");

    // The closing word of a matrix sits at the bottom right corner.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (DW'(out_row_reg) + DW'(1) == m_dim) && (DW'(out_col_reg) + DW'(1) == n_dim))
        else $error("last word not at final row and column");

endmodule
